// ----- rtl/enveloped_sine_tone_mixer_unit_defines.svh -----
// Assertion macros shared by the enveloped sine tone mixer RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ENVELOPED_SINE_TONE_MIXER_UNIT_DEFINES_SVH
`define ENVELOPED_SINE_TONE_MIXER_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define ESTM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ESTM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/estm_pkg.sv -----
// Shared types, constants and the sine table of the enveloped sine tone mixer.
// Depends on nothing; the interfaces, the divider and the mixer import it.
package estm_pkg;

  localparam int DEF_SAMPLE_RATE = 22050;
  localparam int DEF_INDEX_BITS  = 16;

  localparam int TONE_HZ_W   = 14;
  localparam int LEN_W       = 16;
  localparam int VOL_W       = 8;
  localparam int SAMPLE_W    = 8;
  localparam int PHASE_W     = 17;
  localparam int FRAC_BITS   = 12;
  localparam int SINE_ADDR_W = 5;
  localparam int SINE_MAG_W  = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int VOL_FULL    = 255;
  localparam int SAMPLE_MAX  = 255;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TONE_HZ,
    REG_TONE_LENGTH,
    REG_START_VOLUME,
    REG_END_VOLUME
  } estm_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_VOL,
    ST_DIV_VOL,
    ST_MUL_VOICE,
    ST_DIV_VOICE,
    ST_FINISH
  } estm_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } estm_div_status_t;

  localparam logic signed [7:0] SINE_ROM [32] = '{
       8'sd0,   8'sd25,   8'sd49,   8'sd71,   8'sd90,  8'sd106,  8'sd117,  8'sd125,
     8'sd127,  8'sd125,  8'sd117,  8'sd106,   8'sd90,   8'sd71,   8'sd49,   8'sd25,
       8'sd0,  -8'sd25,  -8'sd49,  -8'sd71,  -8'sd90, -8'sd106, -8'sd117, -8'sd125,
    -8'sd127, -8'sd125, -8'sd117, -8'sd106,  -8'sd90,  -8'sd71,  -8'sd49,  -8'sd25
  };

  function automatic logic signed [7:0] sine_value(input logic [SINE_ADDR_W-1:0] addr);
    return SINE_ROM[addr];
  endfunction

endpackage

// ----- rtl/estm_channels_if.sv -----
// Valid/ready channel interfaces for the input and result items of the mixer.
// Depends on estm_pkg for the sample width.
interface estm_in_if;
  import estm_pkg::*;
  logic                valid;
  logic                ready;
  logic                restart;
  logic [SAMPLE_W-1:0] background_sample;

  modport source (output valid, output restart, output background_sample, input ready);
  modport sink (input valid, input restart, input background_sample, output ready);
endinterface

interface estm_out_if;
  import estm_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] mixed_sample;
  logic                tone_active;

  modport source (output valid, output mixed_sample, output tone_active, input ready);
  modport sink (input valid, input mixed_sample, input tone_active, output ready);
endinterface

// ----- rtl/estm_serial_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
// Depends on estm_pkg. The caller guarantees dividend < divisor * 2**QW.
module estm_serial_div #(
  parameter int DW = 24,
  parameter int VW = 16,
  parameter int QW = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [DW-1:0]               dividend,
  input  logic [VW-1:0]               divisor,
  output estm_pkg::estm_div_status_t  status,
  output logic [QW-1:0]               quotient
);
  import estm_pkg::*;

  localparam int CW = (QW > 1) ? $clog2(QW) : 1;

  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [QW-1:0] qsh;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  // The low dividend bits shift out of qsh while quotient bits shift in.
  always_comb begin
    trial = {rem, qsh[QW-1]};
    diff  = trial - {1'b0, dvs};
    ge    = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == CW'(QW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= VW'(dividend >> QW);
      qsh <= dividend[QW-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
      qsh <= {qsh[QW-2:0], ge};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = qsh;

endmodule

// ----- rtl/enveloped_sine_tone_mixer_unit.sv -----
// Enveloped sine tone mixer: adds an enveloped sine voice to 8-bit samples.
// A sample with tone goes from accept through the volume multiply and divide and
// the voice multiply and divide; with the tone off it goes straight to finish.
// One item at a time, on a serial multiplier (one bit per cycle) and the shared divider.
// A tone_hz write recomputes the phase step; input waits meanwhile.
// Synchronous active-high reset clears config registers, step, phase, sample index and output valid.
`include "enveloped_sine_tone_mixer_unit_defines.svh"

module enveloped_sine_tone_mixer_unit #(
  parameter int SAMPLE_RATE = estm_pkg::DEF_SAMPLE_RATE,
  parameter int INDEX_BITS  = estm_pkg::DEF_INDEX_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [estm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [estm_pkg::CFG_DATA_W-1:0]  cfg_data,
  estm_in_if.sink                          background,
  estm_out_if.source                       mixed
);
  import estm_pkg::*;

  // Phase step divider: dividend is tone_hz shifted up by 5 + 12 bits.
  localparam int STEP_DW  = TONE_HZ_W + PHASE_W;
  localparam int STEP_VW  = $clog2(SAMPLE_RATE + 1);
  localparam longint STEP_MAX = ((64'(1) << TONE_HZ_W) - 1) * (64'(1) << PHASE_W)
                                / SAMPLE_RATE;
  localparam int STEP_QW  = $clog2(STEP_MAX + 1);
  // Item divider: volume slope product, then sine times volume.
  localparam int ITEM_DW  = VOL_W + INDEX_BITS;
  localparam int CNT_W    = $clog2(INDEX_BITS);
  localparam int CMP_W    = (INDEX_BITS > LEN_W) ? INDEX_BITS : LEN_W;

  // Configuration registers.
  logic [TONE_HZ_W-1:0] tone_hz;
  logic [LEN_W-1:0]     tone_length;
  logic [VOL_W-1:0]     start_volume;
  logic [VOL_W-1:0]     end_volume;
  logic [PHASE_W-1:0]   step;

  // Oscillator state.
  logic [PHASE_W-1:0]    phase_accum;
  logic [INDEX_BITS-1:0] sample_index;

  estm_state_t state;
  estm_state_t state_next;

  // Working registers of the current item.
  logic [SAMPLE_W-1:0]   bg;
  logic                  vol_neg;
  logic                  voice_neg;
  logic [VOL_W-1:0]      mhi;
  logic [INDEX_BITS-1:0] mlo;
  logic [VOL_W-1:0]      mcand;
  logic [CNT_W-1:0]      cnt;
  logic [SAMPLE_W-1:0]   res_sample;
  logic                  res_active;

  // Output register.
  logic                out_valid;
  logic [SAMPLE_W-1:0] out_sample;
  logic                out_active;

  // Combinational helpers.
  logic                  accept;
  logic                  out_free;
  logic [INDEX_BITS-1:0] idx_eff;
  logic [PHASE_W-1:0]    phase_eff;
  logic                  act;
  logic [VOL_W:0]        msum;
  logic [VOL_W-1:0]      mhi_n;
  logic [INDEX_BITS-1:0] mlo_n;
  logic                  mul_last;
  logic [VOL_W-1:0]      vol;
  logic signed [7:0]     sine_s;
  logic [SINE_MAG_W-1:0] sine_mag;
  logic [SAMPLE_W+1:0]   voice_ext;
  logic [SAMPLE_W+1:0]   sum;
  logic [SAMPLE_W-1:0]   sat_sample;

  // Divider connections.
  logic                   vdiv_start;
  logic [ITEM_DW-1:0]     vdiv_dividend;
  logic [LEN_W-1:0]       vdiv_divisor;
  estm_div_status_t       vdiv_st;
  logic [VOL_W-1:0]       vdiv_q;
  logic                   sdiv_start;
  estm_div_status_t       sdiv_st;
  logic [STEP_QW-1:0]     sdiv_q;

  assign accept   = background.valid && background.ready;
  assign out_free = !out_valid || mixed.ready;

  // A restart clears phase and index before the sample is looked at.
  assign idx_eff   = background.restart ? '0 : sample_index;
  assign phase_eff = background.restart ? '0 : phase_accum;
  assign act       = CMP_W'(idx_eff) < CMP_W'(tone_length);

  // One shift-add step of the serial multiplier: the low product bits move
  // into mlo as the multiplier bits move out of it.
  always_comb begin
    msum  = {1'b0, mhi} + (mlo[0] ? {1'b0, mcand} : '0);
    mhi_n = msum[VOL_W:1];
    mlo_n = {msum[0], mlo[INDEX_BITS-1:1]};
  end

  assign mul_last = (state == ST_MUL_VOL) ? (cnt == CNT_W'(INDEX_BITS - 1))
                                          : (cnt == CNT_W'(SINE_MAG_W - 1));

  // The slope quotient is below 256, and the volume stays within its endpoints.
  assign vol = vol_neg ? (start_volume - vdiv_q) : (start_volume + vdiv_q);

  // Sine lookup at phase bits 16..12, split into sign and magnitude.
  always_comb begin
    sine_s   = sine_value(phase_accum[PHASE_W-1:FRAC_BITS]);
    sine_mag = sine_s[7] ? SINE_MAG_W'(-sine_s) : sine_s[SINE_MAG_W-1:0];
  end

  // Mix in offset form: background plus signed voice, clamped to 0..255.
  always_comb begin
    voice_ext = voice_neg ? -{2'b00, vdiv_q} : {2'b00, vdiv_q};
    sum       = {2'b00, bg} + voice_ext;
    if (sum[SAMPLE_W+1]) begin
      sat_sample = '0;
    end else if (sum[SAMPLE_W]) begin
      sat_sample = SAMPLE_W'(SAMPLE_MAX);
    end else begin
      sat_sample = sum[SAMPLE_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = act ? ST_MUL_VOL : ST_FINISH;
        end
      end
      ST_MUL_VOL: begin
        if (mul_last) begin
          state_next = ST_DIV_VOL;
        end
      end
      ST_DIV_VOL: begin
        if (vdiv_st.done) begin
          state_next = ST_MUL_VOICE;
        end
      end
      ST_MUL_VOICE: begin
        if (mul_last) begin
          state_next = ST_DIV_VOICE;
        end
      end
      ST_DIV_VOICE: begin
        if (vdiv_st.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control outputs. The divider starts on the last multiply step and takes
  // the product straight from the step logic.
  always_comb begin
    background.ready = 1'b0;
    vdiv_start       = 1'b0;
    vdiv_dividend    = {mhi_n, mlo_n};
    vdiv_divisor     = tone_length;
    case (state)
      ST_IDLE: begin
        background.ready = !sdiv_st.busy;
      end
      ST_MUL_VOL: begin
        vdiv_start = mul_last;
      end
      ST_MUL_VOICE: begin
        vdiv_start    = mul_last;
        vdiv_dividend = ITEM_DW'({mhi_n, mlo_n[INDEX_BITS-1 -: SINE_MAG_W]});
        vdiv_divisor  = LEN_W'(VOL_FULL);
      end
      default: begin
        vdiv_start = 1'b0;
      end
    endcase
  end

  assign sdiv_start = cfg_we && (cfg_index == REG_TONE_HZ);

  estm_serial_div #(
    .DW (ITEM_DW),
    .VW (LEN_W),
    .QW (VOL_W)
  ) u_item_div (
    .clk      (clk),
    .rst      (rst),
    .start    (vdiv_start),
    .dividend (vdiv_dividend),
    .divisor  (vdiv_divisor),
    .status   (vdiv_st),
    .quotient (vdiv_q)
  );

  // Phase step = tone_hz * 2**17 / SAMPLE_RATE, computed once per tone_hz write.
  estm_serial_div #(
    .DW (STEP_DW),
    .VW (STEP_VW),
    .QW (STEP_QW)
  ) u_step_div (
    .clk      (clk),
    .rst      (rst),
    .start    (sdiv_start),
    .dividend ({cfg_data[TONE_HZ_W-1:0], PHASE_W'(0)}),
    .divisor  (STEP_VW'(SAMPLE_RATE)),
    .status   (sdiv_st),
    .quotient (sdiv_q)
  );

  // Configuration registers and the phase step.
  always_ff @(posedge clk) begin
    if (rst) begin
      tone_hz      <= '0;
      tone_length  <= '0;
      start_volume <= '0;
      end_volume   <= '0;
      step         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TONE_HZ:      tone_hz      <= cfg_data[TONE_HZ_W-1:0];
          REG_TONE_LENGTH:  tone_length  <= cfg_data[LEN_W-1:0];
          REG_START_VOLUME: start_volume <= cfg_data[VOL_W-1:0];
          REG_END_VOLUME:   end_volume   <= cfg_data[VOL_W-1:0];
          default: begin
          end
        endcase
      end
      if (sdiv_st.done) begin
        step <= PHASE_W'(sdiv_q);
      end
    end
  end

  // Control state: sequencer, oscillator state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase_accum  <= '0;
      sample_index <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && accept) begin
        phase_accum  <= phase_eff;
        sample_index <= idx_eff;
      end
      // The oscillator advances only after a sample that carried the tone.
      if (state == ST_DIV_VOICE && vdiv_st.done) begin
        phase_accum <= phase_accum + step;
        if (sample_index != '1) begin
          sample_index <= sample_index + 1'b1;
        end
      end
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (mixed.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers of the item in flight.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          bg         <= background.background_sample;
          res_sample <= background.background_sample;
          res_active <= 1'b0;
          mhi        <= '0;
          mlo        <= idx_eff;
          vol_neg    <= end_volume < start_volume;
          mcand      <= (end_volume < start_volume) ? (start_volume - end_volume)
                                                    : (end_volume - start_volume);
          cnt        <= '0;
        end
      end
      ST_MUL_VOL, ST_MUL_VOICE: begin
        mhi <= mhi_n;
        mlo <= mlo_n;
        cnt <= cnt + 1'b1;
      end
      ST_DIV_VOL: begin
        if (vdiv_st.done) begin
          mhi       <= '0;
          mlo       <= INDEX_BITS'(sine_mag);
          mcand     <= vol;
          voice_neg <= sine_s[7];
          cnt       <= '0;
        end
      end
      ST_DIV_VOICE: begin
        if (vdiv_st.done) begin
          res_sample <= sat_sample;
          res_active <= 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_sample <= res_sample;
          out_active <= res_active;
        end
      end
      default: begin
      end
    endcase
  end

  assign mixed.valid        = out_valid;
  assign mixed.mixed_sample = out_sample;
  assign mixed.tone_active  = out_active;

  // The shared divider is never left running once an item is done.
  `ESTM_ASSERT(a_idle_div_quiet, clk, rst, (state == ST_IDLE) |-> !vdiv_st.busy, "item divider busy while idle")
  // A divider result only ever arrives while the sequencer waits for it.
  `ESTM_ASSERT(a_div_done_expected, clk, rst, vdiv_st.done |-> (state == ST_DIV_VOL || state == ST_DIV_VOICE), "unexpected divider result")
  // The volume multiply hands over to the volume divide and nowhere else.
  `ESTM_ASSERT(a_mul_vol_flow, clk, rst, (state == ST_MUL_VOL) |=> (state == ST_MUL_VOL || state == ST_DIV_VOL), "bad exit from volume multiply")
  // Phase moves only at accept (restart) or at the end of a toned sample.
  `ESTM_ASSERT(a_phase_hold, clk, rst, (state != ST_IDLE && state != ST_DIV_VOICE) |=> $stable(phase_accum), "phase changed mid-item")

endmodule
